// ===== rtl/core/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types, phase codes, result kinds and status constants for the
// MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

  // parse phases
  localparam logic [3:0] PH_FINISHED = 4'd0;
  localparam logic [3:0] PH_DELTA    = 4'd1;
  localparam logic [3:0] PH_STATUS   = 4'd2;
  localparam logic [3:0] PH_DATA1    = 4'd3;
  localparam logic [3:0] PH_DATA2    = 4'd4;
  localparam logic [3:0] PH_METATYPE = 4'd5;
  localparam logic [3:0] PH_SKIPLEN  = 4'd6;
  localparam logic [3:0] PH_SKIP     = 4'd7;

  // result kinds
  localparam logic [2:0] K_DELTA   = 3'd0;
  localparam logic [2:0] K_MSG     = 3'd1;
  localparam logic [2:0] K_TEMPO   = 3'd2;
  localparam logic [2:0] K_EOT     = 3'd3;
  localparam logic [2:0] K_RANOUT  = 3'd4;
  localparam logic [2:0] K_UNKNOWN = 3'd5;

  // status and meta codes
  localparam logic [7:0] ST_DEFAULT_RUN = 8'h80;
  localparam logic [7:0] ST_ONE_LO      = 8'hC0;
  localparam logic [7:0] ST_ONE_HI      = 8'hDF;
  localparam logic [7:0] ST_SYSTEM      = 8'hF0;
  localparam logic [7:0] ST_SYSEX       = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC   = 8'hF7;
  localparam logic [7:0] ST_META        = 8'hFF;
  localparam logic [7:0] META_EOT       = 8'h2F;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [31:0] TEMPO_LEN     = 32'd3;

  // output queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [3:0]  phase;
    logic [7:0]  running_status;
    logic [7:0]  event_status;
    logic [7:0]  first_data;
    logic [31:0] varlen_accum;
    logic [31:0] skip_remaining;
    logic [23:0] tempo_accum;
    logic [1:0]  tempo_bytes_seen;
    logic        tempo_capture;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        last;
  } result_t;

  localparam parse_state_t ST_CLEAR = '{
    phase:            PH_FINISHED,
    running_status:   ST_DEFAULT_RUN,
    event_status:     8'h00,
    first_data:       8'h00,
    varlen_accum:     32'h0,
    skip_remaining:   32'h0,
    tempo_accum:      24'h0,
    tempo_bytes_seen: 2'd0,
    tempo_capture:    1'b0
  };

  function automatic logic one_data_byte(input logic [7:0] st);
    return st inside {[ST_ONE_LO:ST_ONE_HI]};
  endfunction

endpackage

// ===== rtl/core/mtep_if.sv =====
// ----------------------------------------------------------------------------
// mtep_if
// Valid/ready channels of the MIDI track event parser: byte input and
// result output.
// ----------------------------------------------------------------------------
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       track_start;
  logic       chunk_end;

  modport source (output valid, data_byte, track_start, chunk_end, input ready);
  modport sink   (input valid, data_byte, track_start, chunk_end, output ready);
endinterface

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [31:0] result_value;
  logic        last_of_run;

  modport source (output valid, result_kind, result_value, last_of_run, input ready);
  modport sink   (input valid, result_kind, result_value, last_of_run, output ready);
endinterface

// ===== rtl/core/mtep_step.sv =====
// ----------------------------------------------------------------------------
// mtep_step
// One-byte parse step: next parser state and up to two results.
// ----------------------------------------------------------------------------
module mtep_step import mtep_pkg::*; (
  input  parse_state_t cur_state,
  input  logic [7:0]   data_byte,
  input  logic         track_start,
  input  logic         chunk_end,
  output parse_state_t nxt_state,
  output result_t      res0,
  output result_t      res1,
  output logic [1:0]   push_cnt
);

  parse_state_t s;
  logic         main_v;
  logic [2:0]   main_kind;
  logic [31:0]  main_val;
  logic         ranout;
  logic [31:0]  acc7;
  logic [31:0]  skip_dec;
  logic [23:0]  tempo_shift;

  always_comb begin
    s         = cur_state;
    main_v    = 1'b0;
    main_kind = K_DELTA;
    main_val  = 32'h0;
    if (track_start) begin
      s       = ST_CLEAR;
      s.phase = PH_DELTA;
    end
    acc7        = {s.varlen_accum[24:0], data_byte[6:0]};
    skip_dec    = s.skip_remaining - 32'd1;
    tempo_shift = {s.tempo_accum[15:0], data_byte};

    if (s.phase != PH_FINISHED) begin
      case (s.phase)
        PH_DELTA: begin
          s.varlen_accum = acc7;
          if (!data_byte[7]) begin
            main_v         = 1'b1;
            main_kind      = K_DELTA;
            main_val       = acc7;
            s.varlen_accum = 32'h0;
            s.phase        = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (data_byte < ST_SYSTEM) begin
            if (data_byte[7]) begin
              s.running_status = data_byte;
              s.event_status   = data_byte;
              s.phase          = PH_DATA1;
            end else begin
              // running status: this byte is already the first data byte
              s.event_status = s.running_status;
              s.first_data   = data_byte;
              if (one_data_byte(s.running_status)) begin
                main_v    = 1'b1;
                main_kind = K_MSG;
                main_val  = {16'h0, data_byte, s.running_status};
                s.phase   = PH_DELTA;
              end else begin
                s.phase = PH_DATA2;
              end
            end
          end else if (data_byte == ST_SYSEX || data_byte == ST_SYSEX_ESC) begin
            s.tempo_capture = 1'b0;
            s.varlen_accum  = 32'h0;
            s.phase         = PH_SKIPLEN;
          end else if (data_byte == ST_META) begin
            s.phase = PH_METATYPE;
          end else begin
            main_v    = 1'b1;
            main_kind = K_UNKNOWN;
            main_val  = {24'h0, data_byte};
            s.phase   = PH_FINISHED;
          end
        end
        PH_DATA1: begin
          s.first_data = data_byte;
          if (one_data_byte(s.event_status)) begin
            main_v    = 1'b1;
            main_kind = K_MSG;
            main_val  = {16'h0, data_byte, s.event_status};
            s.phase   = PH_DELTA;
          end else begin
            s.phase = PH_DATA2;
          end
        end
        PH_DATA2: begin
          main_v    = 1'b1;
          main_kind = K_MSG;
          main_val  = {8'h0, data_byte, s.first_data, s.event_status};
          s.phase   = PH_DELTA;
        end
        PH_METATYPE: begin
          if (data_byte == META_EOT) begin
            main_v    = 1'b1;
            main_kind = K_EOT;
            s.phase   = PH_FINISHED;
          end else begin
            s.tempo_capture = (data_byte == META_TEMPO);
            s.varlen_accum  = 32'h0;
            s.phase         = PH_SKIPLEN;
          end
        end
        PH_SKIPLEN: begin
          s.varlen_accum = acc7;
          if (!data_byte[7]) begin
            s.skip_remaining   = acc7;
            s.varlen_accum     = 32'h0;
            s.tempo_capture    = s.tempo_capture && (acc7 == TEMPO_LEN);
            s.tempo_accum      = 24'h0;
            s.tempo_bytes_seen = 2'd0;
            s.phase            = (acc7 == 32'h0) ? PH_DELTA : PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (s.tempo_capture) begin
            s.tempo_accum      = tempo_shift;
            s.tempo_bytes_seen = s.tempo_bytes_seen + 2'd1;
          end
          s.skip_remaining = skip_dec;
          if (skip_dec == 32'h0) begin
            if (s.tempo_capture) begin
              main_v    = 1'b1;
              main_kind = K_TEMPO;
              main_val  = {8'h0, tempo_shift};
            end
            s.tempo_capture = 1'b0;
            s.phase         = PH_DELTA;
          end
        end
        default: begin
          s.phase = PH_FINISHED;
        end
      endcase
    end

    // chunk ran out while the track is still open
    ranout = chunk_end && (s.phase != PH_FINISHED);
    if (ranout) begin
      s.phase = PH_FINISHED;
    end

    nxt_state = s;
    if (main_v) begin
      res0 = '{kind: main_kind, value: main_val, last: !ranout};
    end else begin
      res0 = '{kind: K_RANOUT, value: 32'h0, last: 1'b1};
    end
    res1     = '{kind: K_RANOUT, value: 32'h0, last: 1'b1};
    push_cnt = {1'b0, main_v} + {1'b0, ranout};
  end

endmodule

// ===== rtl/core/mtep_out_fifo.sv =====
// ----------------------------------------------------------------------------
// mtep_out_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module mtep_out_fifo import mtep_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  result_t    push0,
  input  result_t    push1,
  output logic       room,
  output logic       pop_valid,
  input  logic       pop_ready,
  output result_t    pop_data,
  output logic [OUT_CNT_W-1:0] count
);

  result_t              mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OUT_PTR_W-1:0] wr_ptr_p1;
  logic                 pop;

  assign pop        = pop_valid && pop_ready;
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  // two free entries, so a two-result byte always fits
  assign room       = (cnt_r <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign count      = cnt_r;
  assign wr_ptr_p1  = wr_ptr_r + OUT_PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + OUT_PTR_W'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + OUT_PTR_W'(pop);
  assign cnt_nxt    = cnt_r + OUT_CNT_W'(push_cnt) - OUT_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

endmodule

// ===== rtl/core/midi_track_event_parser.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Parses standard MIDI file track chunk bytes into delta, channel message,
// tempo, end of track, data ran out and unknown status results.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one track byte per item with track_start and chunk_end
//   flags; out_ch carries result items (kind, value, last_of_run).
//   A byte is captured in an input register, parsed once the output queue
//   has room and its results written to the four-entry output queue; the
//   first result is offered from the queue after that write.
//   Throughput is one byte per cycle while the queue has room. Most bytes
//   give zero or one result; a byte that gives two (a final token plus
//   data ran out) writes both to the queue at once. The queue accepts a
//   parse step only while it has two free entries, so in_ch.ready drops
//   once a byte is held and more than two results wait.
//   When the receiver stalls, results stay queued and in order, and the
//   input stalls once more than two results are queued.
//   After reset the parser is finished: bytes are dropped until one comes
//   with track_start, which clears running status to 0x80 and starts the
//   initial delta time.
// ----------------------------------------------------------------------------
module midi_track_event_parser import mtep_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  mtep_in_if.sink     in_ch,
  mtep_out_if.source  out_ch
);

  logic         in_v_r;
  logic [7:0]   in_byte_r;
  logic         in_start_r;
  logic         in_end_r;
  logic         in_acc;
  logic         fire;
  logic         room;

  parse_state_t state_r, state_nxt;
  result_t      res0, res1, pop_data;
  logic [1:0]   step_cnt, push_cnt;
  logic [OUT_CNT_W-1:0] q_count;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign fire        = in_v_r && room;
  assign in_ch.ready = !in_v_r || fire;
  assign push_cnt    = fire ? step_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r  <= in_ch.data_byte;
      in_start_r <= in_ch.track_start;
      in_end_r   <= in_ch.chunk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  mtep_step u_step (
    .cur_state   (state_r),
    .data_byte   (in_byte_r),
    .track_start (in_start_r),
    .chunk_end   (in_end_r),
    .nxt_state   (state_nxt),
    .res0        (res0),
    .res1        (res1),
    .push_cnt    (step_cnt)
  );

  mtep_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .pop_valid (out_ch.valid),
    .pop_ready (out_ch.ready),
    .pop_data  (pop_data),
    .count     (q_count)
  );

  assign out_ch.result_kind  = pop_data.kind;
  assign out_ch.result_value = pop_data.value;
  assign out_ch.last_of_run  = pop_data.last;

  // queue never overflows
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue overflow");

  // a held input byte stays put until it is parsed
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !fire) |=> (in_v_r && $stable(in_byte_r) && $stable(in_end_r)))
    else $error("input stage changed while waiting");

  // the final byte of a chunk always leaves the parser finished
  a_chunk_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_end_r) |=> (state_r.phase == PH_FINISHED))
    else $error("parser still active after chunk end");

  // no results while finished without a track start
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !in_start_r && state_r.phase == PH_FINISHED) |-> (push_cnt == 2'd0))
    else $error("result from a finished parser");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIDI track event parser. Track chunks are
// generated as byte streams: mostly well-formed event sequences with random
// content, plus truncated chunks, unknown status bytes, abandoned tracks and
// stray bytes. Each accepted byte runs through a parser model in the
// scoreboard, and every result item is compared with the oldest expected
// token. Both channels idle and stall at random, except near the end.
// ----------------------------------------------------------------------------
module tb_top import mtep_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 1100;
  localparam int CALM_FROM      = 950;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct {
    logic [7:0] data_byte;
    bit         track_start;
    bit         chunk_end;
  } track_byte_t;

  // --------------------------------------------------------------------------
  class token_scoreboard;
    logic [3:0]  phase;
    logic [7:0]  run_status;
    logic [7:0]  ev_status;
    logic [7:0]  data1;
    logic [31:0] vlq;
    logic [31:0] skip_left;
    logic [23:0] tempo;
    logic [1:0]  tempo_cnt;
    logic        tempo_on;
    result_t     byte_tokens[$];
    result_t     awaited_tokens[$];
    int          mismatches;
    int          matched;
    int          kind_count[6];

    function new();
      clear_parse();
      phase = PH_FINISHED;
    endfunction

    function void clear_parse();
      run_status = ST_DEFAULT_RUN;
      ev_status  = '0;
      data1      = '0;
      vlq        = '0;
      skip_left  = '0;
      tempo      = '0;
      tempo_cnt  = '0;
      tempo_on   = 1'b0;
    endfunction

    function void emit(logic [2:0] kind, logic [31:0] value);
      byte_tokens.push_back('{kind: kind, value: value, last: 1'b1});
    endfunction

    function void take_data1(logic [7:0] b);
      data1 = b;
      if (ev_status[7:5] == 3'b110) begin
        emit(K_MSG, {16'h0, data1, ev_status});
        phase = PH_DELTA;
      end else begin
        phase = PH_DATA2;
      end
    endfunction

    function void predict_byte(logic [7:0] b, bit start, bit fin);
      result_t t;
      byte_tokens.delete();
      if (start) begin
        clear_parse();
        phase = PH_DELTA;
      end
      if (phase == PH_FINISHED) return;
      case (phase)
        PH_DELTA: begin
          vlq = (vlq << 7) + b[6:0];
          if (!b[7]) begin
            emit(K_DELTA, vlq);
            vlq   = '0;
            phase = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b < ST_SYSTEM) begin
            if (b[7]) begin
              run_status = b;
              ev_status  = b;
              phase      = PH_DATA1;
            end else begin
              ev_status = run_status;
              take_data1(b);
            end
          end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
            tempo_on = 1'b0;
            vlq      = '0;
            phase    = PH_SKIPLEN;
          end else if (b == ST_META) begin
            phase = PH_METATYPE;
          end else begin
            emit(K_UNKNOWN, {24'h0, b});
            phase = PH_FINISHED;
          end
        end
        PH_DATA1: take_data1(b);
        PH_DATA2: begin
          emit(K_MSG, {8'h0, b, data1, ev_status});
          phase = PH_DELTA;
        end
        PH_METATYPE: begin
          if (b == META_EOT) begin
            emit(K_EOT, '0);
            phase = PH_FINISHED;
          end else begin
            tempo_on = (b == META_TEMPO);
            vlq      = '0;
            phase    = PH_SKIPLEN;
          end
        end
        PH_SKIPLEN: begin
          vlq = (vlq << 7) + b[6:0];
          if (!b[7]) begin
            skip_left = vlq;
            vlq       = '0;
            tempo_on  = tempo_on && (skip_left == TEMPO_LEN);
            tempo     = '0;
            tempo_cnt = '0;
            phase     = (skip_left == 0) ? PH_DELTA : PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (tempo_on) begin
            tempo     = {tempo[15:0], b};
            tempo_cnt = tempo_cnt + 2'd1;
          end
          skip_left = skip_left - 1;
          if (skip_left == 0) begin
            if (tempo_on) emit(K_TEMPO, {8'h0, tempo});
            tempo_on = 1'b0;
            phase    = PH_DELTA;
          end
        end
        default: phase = PH_FINISHED;
      endcase
      // chunk ran out while a token was still open
      if (fin && phase != PH_FINISHED) begin
        emit(K_RANOUT, '0);
        phase = PH_FINISHED;
      end
      foreach (byte_tokens[i]) begin
        t      = byte_tokens[i];
        t.last = (i == byte_tokens.size() - 1);
        awaited_tokens.push_back(t);
      end
    endfunction

    function void flag(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s: expected kind %0d value %h last %b, got kind %0d value %h last %b",
                 $realtime, what, want.kind, want.value, want.last,
                 got.kind, got.value, got.last);
      end
    endfunction

    function void check_token(logic [2:0] kind, logic [31:0] value, logic last);
      result_t want;
      result_t got;
      got = '{kind: kind, value: value, last: last};
      if (awaited_tokens.size() == 0) begin
        flag("unexpected result", '0, got);
        return;
      end
      want = awaited_tokens.pop_front();
      if (got !== want) begin
        flag("result mismatch", want, got);
      end else begin
        matched++;
        kind_count[want.kind]++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  mtep_in_if  in_ch();
  mtep_out_if out_ch();

  midi_track_event_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  token_scoreboard sb = new();

  track_byte_t trk[$];
  int          stat_pos[$];
  logic [7:0]  gen_run;
  int          gap_odds;
  int          stall_odds;
  int          bytes_sent;
  int          tracks_sent;
  int          idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // stimulus construction
  function automatic void add(logic [7:0] d, bit s = 0, bit e = 0);
    trk.push_back('{data_byte: d, track_start: s, chunk_end: e});
  endfunction

  function automatic logic [7:0] data_val();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, 8'h7F));
    return 8'($urandom_range(0, 8'hFF));
  endfunction

  function automatic void add_delta();
    int n;
    int pick;
    pick = $urandom_range(0, 99);
    n = (pick < 60) ? 1 : (pick < 80) ? 2 : (pick < 90) ? 3 : (pick < 95) ? 4 : 5;
    repeat (n - 1) add(8'h80 | 8'($urandom_range(0, 8'h7F)));
    add(8'($urandom_range(0, 8'h7F)));
  endfunction

  // length with an occasional redundant leading continuation byte
  function automatic void add_body(int len);
    if ($urandom_range(0, 3) == 0) add(8'h80);
    add(len[7:0]);
    repeat (len) add(8'($urandom_range(0, 8'hFF)));
  endfunction

  function automatic void build_track();
    int         pick;
    int         idx;
    logic [7:0] st;
    logic [7:0] u;
    trk.delete();
    stat_pos.delete();
    gen_run = ST_DEFAULT_RUN;
    add_delta();
    trk[0].track_start = 1'b1;
    repeat ($urandom_range(1, 14)) begin
      stat_pos.push_back(trk.size());
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        st = 8'($urandom_range(8'h80, 8'hEF));
        gen_run = st;
        add(st);
        add(data_val());
        if (st[7:5] != 3'b110) add(data_val());
      end else if (pick < 60) begin
        add(8'($urandom_range(0, 8'h7F)));
        if (gen_run[7:5] != 3'b110) add(data_val());
      end else if (pick < 70) begin
        add($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
        add_body($urandom_range(0, 6));
      end else if (pick < 85) begin
        add(ST_META);
        add(META_TEMPO);
        add_body(($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : 3);
      end else begin
        add(ST_META);
        do st = 8'($urandom_range(0, 8'hFF)); while (st == META_EOT);
        add(st);
        add_body($urandom_range(0, 6));
      end
      add_delta();
    end
    pick = $urandom_range(0, 9);
    if (pick == 6) begin
      // cut the chunk short anywhere
      idx = $urandom_range(0, trk.size() - 1);
      trk = trk[0:idx];
      trk[idx].chunk_end = 1'b1;
    end else if (pick == 7) begin
      do u = 8'($urandom_range(8'hF1, 8'hFE)); while (u == ST_SYSEX_ESC);
      add(u, 1'b0, 1'($urandom_range(0, 1)));
    end else if (pick != 8) begin
      // pick 8 leaves the track open; the next track_start restarts it
      add(ST_META);
      add(META_EOT, 1'b0, 1'($urandom_range(0, 1)));
    end
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 2;
      2:       return 4;
      default: return 10;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  task automatic send_byte(track_byte_t it);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= it.data_byte;
    in_ch.track_start <= it.track_start;
    in_ch.chunk_end   <= it.chunk_end;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic play(bit counted);
    foreach (trk[i]) send_byte(trk[i]);
    if (counted) begin
      bytes_sent += trk.size();
      tracks_sent++;
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.predict_byte(in_ch.data_byte, in_ch.track_start, in_ch.chunk_end);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_token(out_ch.result_kind, out_ch.result_value, out_ch.last_of_run);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  initial begin
    gap_odds    = 3;
    stall_odds  = 3;
    bytes_sent  = 0;
    tracks_sent = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.track_start <= 1'b0;
    in_ch.chunk_end   <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed track: note with a high data byte, two-byte delta, one-byte
    // message and its running status, tempo, empty sysex, end of track
    trk.delete();
    add(8'h00, 1); add(8'h90); add(8'h00); add(8'hFF); add(8'h83); add(8'h7F);
    add(8'hD3); add(8'h80); add(8'h00); add(8'h22);
    add(8'h00); add(ST_META); add(META_TEMPO); add(8'h03);
    add(8'h07); add(8'hA1); add(8'h20);
    add(8'h00); add(ST_SYSEX); add(8'h00);
    add(8'h00); add(ST_META); add(META_EOT, 0, 1);
    // ignored while finished, even with chunk end
    add(8'h55, 0, 1);
    // long delta on the start byte, then an unknown status
    add(8'hFF, 1); add(8'h7F); add(8'hF9);
    // short tempo meta cut off by chunk end
    add(8'h00, 1); add(ST_META); add(META_TEMPO); add(8'h02, 0, 1);
    play(1'b1);

    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent < CALM_FROM) begin
        gap_odds   = pick_odds();
        stall_odds = pick_odds();
      end else begin
        gap_odds   = 0;
        stall_odds = 0;
      end
      if ($urandom_range(0, 3) == 0) begin
        trk.delete();
        repeat ($urandom_range(1, 3))
          add(8'($urandom_range(0, 8'hFF)), $urandom_range(0, 7) == 0,
              1'($urandom_range(0, 1)));
        play(1'b0);
      end
      build_track();
      play(1'b1);
    end

    in_ch.valid <= 1'b0;
    while (sb.awaited_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d track bytes in %0d tracks; %0d results matched, %0d mismatches",
             bytes_sent, tracks_sent, sb.matched, sb.mismatches);
    $display("By kind: delta %0d, message %0d, tempo %0d, eot %0d, ran out %0d, unknown %0d",
             sb.kind_count[K_DELTA], sb.kind_count[K_MSG], sb.kind_count[K_TEMPO],
             sb.kind_count[K_EOT], sb.kind_count[K_RANOUT], sb.kind_count[K_UNKNOWN]);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
